@@ hw/rtl/sbs_pkg.sv @@
// ---------------------------------------------------------------------------
// sbs_pkg: shared types and constants of the sinusoid bank synthesizer
// Table entry layout, fixed-point widths and cosine polynomial coefficients.
// ---------------------------------------------------------------------------
`default_nettype none

package sbs_pkg;

	localparam int StepW  = 32;
	localparam int AmpW   = 18;
	localparam int PhaseW = 16;
	localparam int FreqW  = 23;
	localparam int RateW  = 18;
	localparam int OffW   = 10;
	localparam int DvdW   = FreqW + 24;

	// multiplier operand widths, signed
	localparam int MulAW  = 33;
	localparam int MulBW  = 19;
	localparam int MulPW  = MulAW + MulBW;

	localparam int AccW   = 44;

	localparam logic [FreqW-1:0] AudibleMin = 23'd12800;

	// Horner coefficients, innermost first, Q16
	localparam logic [16:0] PolyInit = 17'd60;
	localparam logic [16:0] PolyK [4] = '{17'd1367, 17'd16624, 17'd80852, 17'd65536};
	localparam logic [16:0] CosOne = 17'd65536;

	localparam logic OpLoad   = 1'b0;
	localparam logic OpSample = 1'b1;

	localparam logic CfgSampleRate    = 1'b0;
	localparam logic CfgHarmonicCount = 1'b1;

	typedef struct packed {
		logic [StepW-1:0]  step;
		logic [AmpW-1:0]   amp;
		logic [PhaseW-1:0] phase;
		logic              audible;
	} entry_t;

endpackage

`default_nettype wire

@@ hw/rtl/sbs_mul.sv @@
// ---------------------------------------------------------------------------
// sbs_mul: shared signed multiplier
// One 33x19 signed product, used in turn for angle, square, polynomial and
// amplitude scaling.
// ---------------------------------------------------------------------------
`default_nettype none

module sbs_mul
	import sbs_pkg::*;
(
	input  wire logic signed [MulAW-1:0] a,
	input  wire logic signed [MulBW-1:0] b,
	output logic signed [MulPW-1:0]      p
);

	always_comb begin
		p = MulPW'(a) * MulPW'(b);
	end

endmodule

`default_nettype wire

@@ hw/rtl/sbs_div.sv @@
// ---------------------------------------------------------------------------
// sbs_div: bit-serial restoring divider
// Computes the low 32 bits of (freq << 24) / rate, one quotient bit a cycle.
// ---------------------------------------------------------------------------
`default_nettype none

module sbs_div
	import sbs_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire logic [FreqW-1:0]  freq,
	input  wire logic [RateW-1:0]  rate,
	output logic                   done,
	output logic [StepW-1:0]       quot
);

	localparam int CntW = $clog2(DvdW + 1);

	logic [DvdW-1:0]  dvd_q;
	logic [RateW:0]   rem_q;
	logic [RateW-1:0] dsr_q;
	logic [CntW-1:0]  cnt_q;
	logic             busy_q;
	logic [RateW:0]   trial;
	logic             fits;

	always_comb begin
		trial = {rem_q[RateW-1:0], dvd_q[DvdW-1]};
		fits  = trial >= {1'b0, dsr_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CntW'(DvdW - 1)) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= {freq, 24'd0};
			dsr_q <= rate;
			rem_q <= '0;
			quot  <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[DvdW-2:0], 1'b0};
			rem_q <= fits ? trial - {1'b0, dsr_q} : trial;
			quot  <= {quot[StepW-2:0], fits};
		end
	end

endmodule

`default_nettype wire

@@ hw/rtl/sinusoid_bank_synth.sv @@
// Load beat: serial divider from accept, then table write, then ready returns.
// Sample beat: a summed harmonic runs read, angle, square, polynomial and MAC states;
// a stop entry ends after read and angle; done sets the result valid and ready returns.
// One beat in flight at a time; a waiting result holds a later sample in its last state.
// arst_n clears control state and registers; the harmonic table is not
// cleared and must be loaded before it is read.
// ---------------------------------------------------------------------------
// sinusoid_bank_synth: additive harmonic oscillator bank
// Stores harmonic entries and sums amplitude * cos(step*t + phase).
// ---------------------------------------------------------------------------
`default_nettype none

module sinusoid_bank_synth
	import sbs_pkg::*;
#(
	parameter int MAX_HARMONICS = 128,
	parameter int FRAME_MAX     = 1024
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic        cfg_index,
	input  wire logic [17:0] cfg_data,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	// harmonic_index, frequency, amplitude, phase, sample_offset, zero pad
	input  wire logic [79:0] s_tdata,
	// opcode
	input  wire logic        s_tuser,
	output logic             m_tvalid,
	input  wire logic        m_tready,
	// sample
	output logic [31:0]      m_tdata
);

	localparam int IW = (MAX_HARMONICS > 1) ? $clog2(MAX_HARMONICS) : 1;
	localparam int CW = $clog2(MAX_HARMONICS + 1);
	localparam int TLo = -(FRAME_MAX / 2);
	localparam int THi = FRAME_MAX / 2 - 1;

	typedef enum logic [2:0] {
		S_IDLE, S_DIV, S_RD, S_ANG, S_SQ, S_POLY, S_MAC, S_DONE
	} state_t;

	state_t state_q;

	logic [6:0]               in_idx;
	logic [FreqW-1:0]         in_freq;
	logic [AmpW-1:0]          in_amp;
	logic [PhaseW-1:0]        in_phase;
	logic signed [OffW-1:0]   in_off;

	assign in_idx   = s_tdata[6:0];
	assign in_freq  = s_tdata[29:7];
	assign in_amp   = s_tdata[47:30];
	assign in_phase = s_tdata[63:48];
	assign in_off   = s_tdata[73:64];

	logic [RateW-1:0] sample_rate_q;
	logic [7:0]       harmonic_count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_rate_q    <= 18'd44100;
			harmonic_count_q <= 8'd80;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CfgSampleRate:    sample_rate_q    <= cfg_data;
				CfgHarmonicCount: harmonic_count_q <= cfg_data[7:0];
				default:          ;
			endcase
		end
	end

	logic [CW-1:0]          i_q;

	// harmonic table
	entry_t mem [MAX_HARMONICS];
	entry_t rd_q;
	logic   we;
	entry_t wr_entry;
	logic [IW-1:0] wr_addr_q;

	always_ff @(posedge clk) begin
		if (we)
			mem[wr_addr_q] <= wr_entry;
		rd_q <= mem[i_q[IW-1:0]];
	end

	// divider
	logic             div_start;
	logic             div_done;
	logic [StepW-1:0] div_quot;

	sbs_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.freq   (in_freq),
		.rate   (sample_rate_q),
		.done   (div_done),
		.quot   (div_quot)
	);

	// shared multiplier
	logic signed [MulAW-1:0] mul_a;
	logic signed [MulBW-1:0] mul_b;
	logic signed [MulPW-1:0] mul_p;

	sbs_mul u_mul (
		.a (mul_a),
		.b (mul_b),
		.p (mul_p)
	);

	logic [CW-1:0]          lim_q;
	logic signed [OffW-1:0] t_q;
	logic [31:0]            angle_q;
	logic [14:0]            s_q;
	logic [16:0]            p_q;
	logic [1:0]             hk_q;
	logic signed [17:0]     cos_q;
	logic signed [AccW-1:0] acc_q;
	logic [AmpW-1:0]        amp_ld_q;
	logic [PhaseW-1:0]      phase_ld_q;
	logic                   aud_ld_q;

	logic [13:0]        r;
	logic [14:0]        z;
	logic signed [18:0] diff;
	logic [16:0]        p_next;
	logic signed [AccW-17:0] res;
	logic [31:0]        res_sat;

	always_comb begin
		r    = angle_q[29:16];
		z    = angle_q[30] ? 15'd16384 - {1'b0, r} : {1'b0, r};
		diff = $signed({2'b0, PolyK[hk_q]}) - $signed({2'b0, mul_p[30:14]});
		p_next = diff[18] ? 17'd0 : diff[16:0];
		res  = acc_q[AccW-1:16];
		// a full bank sums to well under 2^31 in Q16, so the int32 limits are never hit
		res_sat = 32'(res);
	end

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			S_ANG: begin
				mul_a = $signed({1'b0, rd_q.step});
				mul_b = MulBW'(t_q);
			end
			S_SQ: begin
				mul_a = $signed(MulAW'(z));
				mul_b = $signed(MulBW'(z));
			end
			S_POLY: begin
				mul_a = $signed(MulAW'(s_q));
				mul_b = $signed(MulBW'(p_q));
			end
			S_MAC: begin
				mul_a = $signed(MulAW'(rd_q.amp));
				mul_b = MulBW'(cos_q);
			end
			default: ;
		endcase
	end

	assign wr_entry = '{step: (sample_rate_q == '0) ? '0 : div_quot,
		amp: amp_ld_q, phase: phase_ld_q, audible: aud_ld_q};
	assign we        = (state_q == S_DIV) && div_done;
	assign s_tready  = (state_q == S_IDLE);
	assign div_start = s_tvalid && s_tready && (s_tuser == OpLoad)
		&& (32'(in_idx) < MAX_HARMONICS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			m_tvalid   <= 1'b0;
			m_tdata    <= '0;
			i_q        <= '0;
			lim_q      <= '0;
			hk_q       <= '0;
			t_q        <= '0;
			acc_q      <= '0;
			angle_q    <= '0;
			s_q        <= '0;
			p_q        <= '0;
			cos_q      <= '0;
			wr_addr_q  <= '0;
			amp_ld_q   <= '0;
			phase_ld_q <= '0;
			aud_ld_q   <= 1'b0;
		end else begin
			if (m_tvalid && m_tready && state_q != S_DONE)
				m_tvalid <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						if (s_tuser == OpSample) begin
							if ($signed(in_off) < TLo)
								t_q <= OffW'(TLo);
							else if ($signed(in_off) > THi)
								t_q <= OffW'(THi);
							else
								t_q <= in_off;
							if ({1'b0, harmonic_count_q} > 9'(MAX_HARMONICS))
								lim_q <= CW'(MAX_HARMONICS);
							else
								lim_q <= CW'(harmonic_count_q);
							i_q   <= '0;
							acc_q <= '0;
							state_q <= (harmonic_count_q == 8'd0) ? S_DONE : S_RD;
						end else if (div_start) begin
							wr_addr_q  <= IW'(in_idx);
							amp_ld_q   <= in_amp;
							phase_ld_q <= in_phase;
							aud_ld_q   <= in_freq >= AudibleMin;
							state_q    <= S_DIV;
						end
					end
				end
				S_DIV: begin
					if (div_done)
						state_q <= S_IDLE;
				end
				S_RD: state_q <= S_ANG;
				S_ANG: begin
					if (i_q != '0 && !rd_q.audible) begin
						state_q <= S_DONE;
					end else begin
						angle_q <= mul_p[31:0] + {rd_q.phase, 16'd0};
						state_q <= S_SQ;
					end
				end
				S_SQ: begin
					s_q     <= mul_p[28:14];
					p_q     <= PolyInit;
					hk_q    <= '0;
					state_q <= S_POLY;
				end
				S_POLY: begin
					hk_q <= hk_q + 1'b1;
					if (hk_q == 2'd3) begin
						// sign from quadrant: negative in the middle two
						if (angle_q[31] ^ angle_q[30])
							cos_q <= -$signed({1'b0, (p_next > CosOne) ? CosOne : p_next});
						else
							cos_q <= $signed({1'b0, (p_next > CosOne) ? CosOne : p_next});
						state_q <= S_MAC;
					end else begin
						p_q <= p_next;
					end
				end
				S_MAC: begin
					acc_q <= acc_q + AccW'(mul_p);
					i_q   <= i_q + 1'b1;
					state_q <= (i_q + 1'b1 == lim_q) ? S_DONE : S_RD;
				end
				S_DONE: begin
					if (!m_tvalid || m_tready) begin
						m_tvalid <= 1'b1;
						m_tdata  <= res_sat;
						state_q  <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

`default_nettype wire

@@ tb/tb.sv @@
// ---------------------------------------------------------------------------
// tb: self-checking bench for sinusoid_bank_synth
// Fills the harmonic bank, then runs directed and random load/sample beats
// over several rate/count settings. Expected samples come from an in-bench
// fixed-point model and are checked against every output beat in order.
// ---------------------------------------------------------------------------
`default_nettype none

module tb
	import sbs_pkg::*;
;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int Banks     = 128;
	localparam int HalfFrame = 512;
	localparam int Settle    = 64;
	localparam longint CycleLimit = 10000000;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic        cfg_index;
	logic [17:0] cfg_data;
	logic        s_tvalid;
	logic        s_tready;
	logic [79:0] s_tdata;  // harmonic_index, frequency, amplitude, phase, sample_offset, pad
	logic        s_tuser;  // opcode
	logic        m_tvalid;
	logic        m_tready;
	logic [31:0] m_tdata;  // sample

	sinusoid_bank_synth dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	// bank model
	logic [StepW-1:0]  bank_step [Banks];
	logic [AmpW-1:0]   bank_amp [Banks];
	logic [PhaseW-1:0] bank_phase [Banks];
	logic              bank_audible [Banks];
	logic [RateW-1:0]  rate_reg;
	logic [7:0]        count_reg;

	logic [31:0] pending_samples[$];
	int          errors;
	longint      cycles;
	bit          calm;      // no idling on either side
	int          hold_req;  // one-shot long receiver stall

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CycleLimit) begin
			$display("tb failed");
			$finish;
		end
	end

	task automatic report(input string what);
		$display("MISMATCH @%0t: %s", $realtime, what);
		errors++;
	endtask

	function automatic longint quarter_cos(input int unsigned z);
		longint s, p;
		s = (longint'(z) * longint'(z)) >>> 14;
		p = 60;
		p = 1367 - ((s * p) >>> 14);   if (p < 0) p = 0;
		p = 16624 - ((s * p) >>> 14);  if (p < 0) p = 0;
		p = 80852 - ((s * p) >>> 14);  if (p < 0) p = 0;
		p = 65536 - ((s * p) >>> 14);  if (p < 0) p = 0;
		if (p > 65536) p = 65536;
		return p;
	endfunction

	function automatic longint turn_cos(input logic [31:0] angle);
		int unsigned r;
		r = angle[29:16];
		case (angle[31:30])
			2'd0: return quarter_cos(r);
			2'd1: return -quarter_cos(16384 - r);
			2'd2: return -quarter_cos(r);
			default: return quarter_cos(16384 - r);
		endcase
	endfunction

	function automatic void store_harmonic(input logic [6:0] idx, input logic [FreqW-1:0] freq,
			input logic [AmpW-1:0] amp, input logic [PhaseW-1:0] ph);
		longint unsigned num;
		num = longint'(freq) << 24;
		bank_step[idx]    = (rate_reg == 0) ? '0 : StepW'(num / longint'(rate_reg));
		bank_amp[idx]     = amp;
		bank_phase[idx]   = ph;
		bank_audible[idx] = (freq >= AudibleMin);
	endfunction

	function automatic logic [31:0] synth_sample(input logic [OffW-1:0] off);
		int          t, n;
		logic [31:0] tu, angle;
		longint      acc, res;
		t = $signed(off);
		if (t < -HalfFrame) t = -HalfFrame;
		if (t > HalfFrame - 1) t = HalfFrame - 1;
		tu = t;
		n = (count_reg > Banks) ? Banks : count_reg;
		acc = 0;
		for (int i = 0; i < n; i++) begin
			if (i > 0 && !bank_audible[i]) break;
			angle = bank_step[i] * tu + {bank_phase[i], 16'h0};
			acc += longint'(bank_amp[i]) * turn_cos(angle);
		end
		res = acc >>> 16;
		if (res > 64'sd2147483647) res = 64'sd2147483647;
		if (res < -64'sd2147483648) res = -64'sd2147483648;
		return res[31:0];
	endfunction

	// sender: one beat, waits for acceptance; valid stays high after it
	task automatic send_beat(input logic op, input logic [6:0] idx, input logic [FreqW-1:0] freq,
			input logic [AmpW-1:0] amp, input logic [PhaseW-1:0] ph, input logic [OffW-1:0] off);
		int gap;
		gap = calm ? 0 : $urandom_range(0, 13);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= {6'd0, off, ph, amp, freq, idx};
		do @(posedge clk); while (!s_tready);
		if (op == OpLoad)
			store_harmonic(idx, freq, amp, ph);
		else
			pending_samples.push_back(synth_sample(off));
	endtask

	task automatic load(input logic [6:0] idx, input logic [FreqW-1:0] freq,
			input logic [AmpW-1:0] amp, input logic [PhaseW-1:0] ph);
		send_beat(OpLoad, idx, freq, amp, ph, OffW'($urandom));
	endtask

	task automatic sample(input logic [OffW-1:0] off);
		send_beat(OpSample, 7'($urandom), FreqW'($urandom), AmpW'($urandom), PhaseW'($urandom), off);
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (pending_samples.size() != 0);
		repeat (Settle) @(posedge clk);
	endtask

	task automatic write_cfg(input logic idx, input logic [17:0] val);
		drain();
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == CfgSampleRate) rate_reg = val;
		else count_reg = val[7:0];
	endtask

	function automatic logic [FreqW-1:0] rand_freq();
		case ($urandom_range(0, 5))
			0: return FreqW'($urandom_range(0, 12799));
			1: return FreqW'($urandom_range(12790, 12810));
			2: return FreqW'($urandom);
			default: return FreqW'($urandom_range(12800, 2000000));
		endcase
	endfunction

	task automatic random_load(input bit audible);
		logic [FreqW-1:0] f;
		f = audible ? FreqW'($urandom_range(12800, 8388607)) : rand_freq();
		load(7'($urandom), f, AmpW'($urandom), PhaseW'($urandom));
	endtask

	// every entry written once, all audible, so any later read is defined
	task automatic test_fill_bank();
		for (int i = 0; i < Banks; i++)
			load(7'(i), FreqW'($urandom_range(12800, 3000000)), AmpW'($urandom), PhaseW'($urandom));
		sample(10'd0);
	endtask

	task automatic test_extremes();
		write_cfg(CfgHarmonicCount, 18'd4);
		load(7'd0, '0, '1, '0);
		load(7'd1, '1, '0, '1);
		load(7'd2, AudibleMin, '1, 16'h4000);
		load(7'd3, FreqW'(12799), 18'h2aaaa, 16'h8000);
		sample(10'h200);
		sample(10'h1ff);
		sample(10'h000);
		sample(10'h3ff);
		load(7'd3, FreqW'(500000), '1, 16'hc000);
		load(7'd127, '1, '1, '1);
		sample(10'h155);
		write_cfg(CfgHarmonicCount, 18'd0);
		sample(10'h2aa);
		write_cfg(CfgHarmonicCount, 18'd255);
		sample(10'h1ff);
		write_cfg(CfgSampleRate, 18'd0);
		load(7'd1, FreqW'(3000000), '1, 16'h1234);
		sample(10'h011);
		write_cfg(CfgSampleRate, 18'h3ffff);
		load(7'd2, '1, '1, '0);
		write_cfg(CfgHarmonicCount, 18'd1);
		sample(10'h200);
		write_cfg(CfgHarmonicCount, 18'd128);
		sample(10'h1ff);
	endtask

	// receiver stalls long, input side must back up
	task automatic test_backpressure();
		write_cfg(CfgHarmonicCount, 18'd3);
		hold_req = 400;
		repeat (8) sample(OffW'($urandom));
		drain();
	endtask

	task automatic test_random(input int beats);
		int settings [6][2] = '{'{44100, 80}, '{8000, 16}, '{192000, 128},
			'{262143, 5}, '{0, 8}, '{48000, 255}};
		for (int ph = 0; ph < 6; ph++) begin
			write_cfg(CfgSampleRate, 18'(settings[ph][0]));
			write_cfg(CfgHarmonicCount, 18'(settings[ph][1]));
			calm = (ph % 3 == 1);
			for (int k = 0; k < beats; k++) begin
				if ($urandom_range(0, 1)) begin
					// mostly audible entries, an occasional stop entry
					random_load($urandom_range(0, 5) != 0);
				end else
					sample(OffW'($urandom));
			end
			calm = 0;
		end
		drain();
	endtask

	always @(posedge clk) begin
		logic [31:0] want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_samples.size() == 0)
				report($sformatf("unexpected sample %h", m_tdata));
			else begin
				want = pending_samples.pop_front();
				if (m_tdata !== want)
					report($sformatf("sample %h, expected %h", m_tdata, want));
			end
		end
	end

	initial begin
		int n;
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			n = calm ? 0 : $urandom_range(0, 13);
			if (hold_req > 0) begin
				n = hold_req;
				hold_req = 0;
			end
			if (n > 0) begin
				m_tready <= 1'b0;
				repeat (n) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
		end
	end

	initial begin
		errors = 0;
		cycles = 0;
		calm = 0;
		hold_req = 0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = CfgSampleRate;
		cfg_data = '0;
		s_tvalid = 1'b0;
		s_tuser = OpLoad;
		s_tdata = '0;
		rate_reg = 18'd44100;
		count_reg = 8'd80;
		for (int i = 0; i < Banks; i++) begin
			bank_step[i] = '0;
			bank_amp[i] = '0;
			bank_phase[i] = '0;
			bank_audible[i] = 1'b0;
		end
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);
		test_fill_bank();
		test_extremes();
		test_backpressure();
		test_random(285);
		drain();
		if (errors == 0)
			$display("tb passed");
		else
			$display("tb failed");
		$finish;
	end

endmodule

`default_nettype wire
